@@ rtl/pstep_pkg.sv @@
// shared constants and types of the plotter step run encoder
package pstep_pkg;

   localparam int RUN_COUNT_BITS = 24;
   localparam int POSITION_BITS = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int BYTE_SLOTS = 4;

   typedef enum logic [1:0] {
      PHASE_LIMIT    = 2'd0,
      PHASE_UNLIMIT  = 2'd1,
      PHASE_SHOWTIME = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      REQ_STEP  = 3'd0,
      REQ_SENSE = 3'd1,
      REQ_MASK  = 3'd2,
      REQ_TICK  = 3'd3,
      REQ_CLEAR = 3'd4
   } req_code_type;

   typedef enum logic [2:0] {
      CSR_X_LIMIT   = 3'd0,
      CSR_HOME_X    = 3'd1,
      CSR_STEP_TICK = 3'd2,
      CSR_PEN_TICK  = 3'd3,
      CSR_IRQ_BITS  = 3'd4
   } csr_index_type;

   localparam logic [3:0] DIR_E  = 4'd1;
   localparam logic [3:0] DIR_W  = 4'd2;
   localparam logic [3:0] DIR_N  = 4'd4;
   localparam logic [3:0] DIR_NE = 4'd5;
   localparam logic [3:0] DIR_NW = 4'd6;
   localparam logic [3:0] DIR_S  = 4'd8;
   localparam logic [3:0] DIR_SE = 4'd9;
   localparam logic [3:0] DIR_SW = 4'd10;
   localparam logic [3:0] DIR_DN = 4'd12;
   localparam logic [3:0] DIR_UP = 4'd14;

   localparam logic [2:0] SENSE_READY     = 3'd1;
   localparam logic [2:0] SENSE_NOT_LIMIT = 3'd2;
   localparam logic [2:0] SENSE_NO_IRQ    = 3'd4;

   typedef struct packed {
      logic [BYTE_SLOTS-1:0][7:0] bytes;
      logic [2:0]                 n_bytes;
      logic                       skip;
      logic                       error;
      logic [15:0]                irq;
      logic                       at_limit;
      logic                       pen_down;
      logic [15:0]                x_pos;
      logic [15:0]                y_pos;
   } rsp_entry_type;

endpackage

@@ rtl/pstep_if.sv @@
// request and response channel interfaces
interface pstep_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [3:0]  function_code;
   logic [15:0] mask_value;

   modport source (output valid, output req_type, output function_code, output mask_value,
                   input ready);
   modport sink (input valid, input req_type, input function_code, input mask_value,
                 output ready);
endinterface

interface pstep_rsp_if;
   logic               valid;
   logic               ready;
   logic [7:0]         out_byte;
   logic               byte_valid;
   logic               last;
   logic               skip;
   logic [15:0]        interrupt_request;
   logic               error;
   logic               at_limit;
   logic               pen_down;
   logic signed [15:0] x_position;
   logic signed [15:0] y_position;

   modport source (output valid, output out_byte, output byte_valid, output last,
                   output skip, output interrupt_request, output error, output at_limit,
                   output pen_down, output x_position, output y_position, input ready);
   modport sink (input valid, input out_byte, input byte_valid, input last,
                 input skip, input interrupt_request, input error, input at_limit,
                 input pen_down, input x_position, input y_position, output ready);
endinterface

@@ rtl/plotter_step_run_encoder.sv @@
// top level of the plotter step run encoder
//
// req_bus carries commands (step, sense, set mask, tick, master clear) under
// valid/ready; a command is taken at a clock edge where both are high.
// rsp_bus returns the results under valid/ready: one beat per command, or
// one beat per plot byte (up to four) when the command flushes a run, with
// last set on the final beat and the status fields repeated in each.
// csr_we/csr_index/csr_wdata write the configuration registers.
// The front decodes a command and updates position, pen and run state in the
// cycle it is taken; its results enter a two-entry queue, and the back offers
// the head entry as beats. The front takes a command every cycle while the
// queue has room; the back drains one beat per cycle while the receiver is
// ready, so a command takes one beat, or one per byte of a flushed run.
// A stalled receiver holds the current beat; the queue fills and req ready
// drops only when both entries are waiting.
// Reset (synchronous, active high) restores register and state defaults at
// once and empties the queue.
module plotter_step_run_encoder
   import pstep_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   pstep_req_if.sink    req_bus,
   pstep_rsp_if.source  rsp_bus,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [23:0]  csr_wdata
);

   rsp_entry_type push_entry;
   rsp_entry_type head;
   logic          q_push;
   logic          q_full;
   logic          q_pop;
   logic          q_empty;

   pstep_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (push_entry)
   );

   pstep_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (head),
      .empty      (q_empty)
   );

   pstep_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .empty   (q_empty),
      .pop     (q_pop),
      .rsp_bus (rsp_bus)
   );

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_bus.valid)
      else $error("response valid right after reset");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.byte_valid |-> rsp_bus.last && rsp_bus.out_byte == 8'd0)
      else $error("status beat not single or carries a byte");

   a_error_no_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.error |-> !rsp_bus.byte_valid)
      else $error("rejected command produced plot bytes");

   a_beat_order: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.ready && !rsp_bus.last |=> rsp_bus.valid && rsp_bus.byte_valid)
      else $error("run flush cut short");
`endif

endmodule

@@ rtl/pstep_front.sv @@
// front end: config registers, command decode, plotter state and run encoding
module pstep_front
   import pstep_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   pstep_req_if.sink          req_bus,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_wdata,
   input  logic               q_full,
   output logic               q_push,
   output rsp_entry_type      q_entry
);

   typedef struct packed {
      logic [BYTE_SLOTS-1:0][7:0] bytes;
      logic [2:0]                 n;
   } run_bytes_type;

   localparam int RUN_MAX_BITS = (RUN_COUNT_BITS > 24) ? 24 : RUN_COUNT_BITS;
   localparam logic [RUN_COUNT_BITS-1:0] RUN_MAX =
      RUN_COUNT_BITS'((64'd1 << RUN_MAX_BITS) - 64'd1);

   localparam logic [14:0] X_LIMIT_RESET   = 15'd4096;
   localparam logic [23:0] STEP_TICK_RESET = 24'd3333;
   localparam logic [23:0] PEN_TICK_RESET  = 24'd50000;
   localparam logic [15:0] IRQ_BITS_RESET  = 16'd1;

   function automatic logic at_limit_of(input logic [POSITION_BITS-1:0] x,
                                        input logic [14:0] lim);
      return x[POSITION_BITS-1] || (32'(x) >= 32'(lim));
   endfunction

   function automatic logic dir_legal(input logic [3:0] d);
      logic ok;
      ok = (d != 4'd0) && !(d[0] && d[1]) && !(d[2] && d[3]);
      return ok || (d == DIR_DN) || (d == DIR_UP);
   endfunction

   function automatic run_bytes_type encode_run(input logic [3:0] dir,
                                                input logic [23:0] cnt);
      run_bytes_type r;
      logic [7:0]    fin;
      fin = {1'b0, dir, cnt[2:0]};
      r.bytes = '0;
      if (cnt <= 24'd7) begin
         r.n = 3'd1;
         r.bytes[0] = fin;
      end else if (cnt < 24'd1024) begin
         r.n = 3'd2;
         r.bytes[0] = {1'b1, cnt[9:3]};
         r.bytes[1] = fin;
      end else if (cnt < 24'd131072) begin
         r.n = 3'd3;
         r.bytes[0] = {1'b1, cnt[16:10]};
         r.bytes[1] = {1'b1, cnt[9:3]};
         r.bytes[2] = fin;
      end else begin
         r.n = 3'd4;
         r.bytes[0] = {1'b1, cnt[23:17]};
         r.bytes[1] = {1'b1, cnt[16:10]};
         r.bytes[2] = {1'b1, cnt[9:3]};
         r.bytes[3] = fin;
      end
      return r;
   endfunction

   logic [14:0]               x_limit_ff;
   logic [23:0]               step_ticks_ff;
   logic [23:0]               pen_ticks_ff;
   logic [15:0]               irq_bits_ff;

   logic [POSITION_BITS-1:0]  x_ff, x_in;
   logic [POSITION_BITS-1:0]  y_ff, y_in;
   logic                      pen_ff, pen_in;
   phase_type                 phase_ff, phase_in;
   logic [15:0]               mask_ff, mask_in;
   logic                      ready_ff, ready_in;
   logic [23:0]               busy_ff, busy_in;
   logic [3:0]                run_dir_ff, run_dir_in;
   logic [RUN_COUNT_BITS-1:0] run_cnt_ff, run_cnt_in;

   logic                      accept;
   logic                      home_we;
   logic                      flush;
   logic                      skip;
   logic                      err;
   logic                      lim_new;
   phase_type                 step_phase;
   logic [3:0]                fc;
   logic [31:0]               run_cnt_wide;
   run_bytes_type             enc;

   assign fc = req_bus.function_code;
   assign req_bus.ready = !q_full;
   assign accept = req_bus.valid && !q_full;
   assign q_push = accept;
   assign home_we = csr_we && (csr_index_type'(csr_index) == CSR_HOME_X);

   assign run_cnt_wide = 32'(run_cnt_ff);
   assign enc = encode_run(run_dir_ff, run_cnt_wide[23:0]);

   always_comb begin
      x_in       = x_ff;
      y_in       = y_ff;
      pen_in     = pen_ff;
      phase_in   = phase_ff;
      mask_in    = mask_ff;
      ready_in   = ready_ff;
      busy_in    = busy_ff;
      run_dir_in = run_dir_ff;
      run_cnt_in = run_cnt_ff;
      flush      = 1'b0;
      skip       = 1'b0;
      err        = 1'b0;
      step_phase = phase_ff;
      lim_new    = 1'b0;
      unique case (req_code_type'(req_bus.req_type))
         REQ_STEP: begin
            if (dir_legal(fc)) begin
               step_phase = (fc == DIR_DN) ? PHASE_SHOWTIME : phase_ff;
               if (step_phase == PHASE_SHOWTIME) begin
                  if (fc == run_dir_ff && run_cnt_ff < RUN_MAX) begin
                     run_cnt_in = run_cnt_ff + RUN_COUNT_BITS'(1);
                  end else begin
                     flush      = (run_dir_ff != 4'd0);
                     run_dir_in = fc;
                     run_cnt_in = '0;
                  end
               end
               if (fc == DIR_UP) begin
                  pen_in = 1'b0;
               end else if (fc == DIR_DN) begin
                  pen_in = 1'b1;
               end else begin
                  if ((fc & DIR_N) != 4'd0) y_in = y_ff + POSITION_BITS'(1);
                  if ((fc & DIR_S) != 4'd0) y_in = y_ff - POSITION_BITS'(1);
                  if ((fc & DIR_E) != 4'd0) x_in = x_ff + POSITION_BITS'(1);
                  if ((fc & DIR_W) != 4'd0) x_in = x_ff - POSITION_BITS'(1);
               end
               lim_new = at_limit_of(x_in, x_limit_ff);
               if (step_phase == PHASE_LIMIT && lim_new) begin
                  phase_in = PHASE_UNLIMIT;
               end else if (step_phase == PHASE_UNLIMIT && !lim_new) begin
                  phase_in = PHASE_SHOWTIME;
               end else begin
                  phase_in = step_phase;
               end
               ready_in = 1'b0;
               busy_in  = (fc == DIR_DN || fc == DIR_UP) ? pen_ticks_ff : step_ticks_ff;
            end else begin
               err = 1'b1;
            end
         end
         REQ_SENSE: begin
            unique case (fc[2:0])
               SENSE_READY:     skip = ready_ff;
               SENSE_NOT_LIMIT: skip = !at_limit_of(x_ff, x_limit_ff);
               SENSE_NO_IRQ:    skip = !(ready_ff && mask_ff != 16'd0);
               default:         err = 1'b1;
            endcase
         end
         REQ_MASK: begin
            mask_in = req_bus.mask_value & irq_bits_ff;
         end
         REQ_TICK: begin
            if (busy_ff > 24'd1) begin
               busy_in = busy_ff - 24'd1;
            end else begin
               busy_in  = '0;
               ready_in = 1'b1;
            end
         end
         REQ_CLEAR: begin
            flush      = (run_dir_ff != 4'd0);
            phase_in   = PHASE_LIMIT;
            y_in       = '0;
            pen_in     = 1'b0;
            run_dir_in = '0;
            run_cnt_in = '0;
            mask_in    = '0;
            ready_in   = 1'b1;
            busy_in    = '0;
         end
         default: ;
      endcase
   end

   always_comb begin
      q_entry          = '0;
      q_entry.bytes    = flush ? enc.bytes : '0;
      q_entry.n_bytes  = flush ? enc.n : 3'd0;
      q_entry.skip     = skip;
      q_entry.error    = err;
      q_entry.irq      = (ready_in && mask_in != 16'd0) ? mask_in : 16'd0;
      q_entry.at_limit = at_limit_of(x_in, x_limit_ff);
      q_entry.pen_down = pen_in;
      q_entry.x_pos    = 16'(32'(x_in));
      q_entry.y_pos    = 16'(32'(y_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_limit_ff    <= X_LIMIT_RESET;
         step_ticks_ff <= STEP_TICK_RESET;
         pen_ticks_ff  <= PEN_TICK_RESET;
         irq_bits_ff   <= IRQ_BITS_RESET;
         x_ff          <= '0;
         y_ff          <= '0;
         pen_ff        <= 1'b0;
         phase_ff      <= PHASE_LIMIT;
         mask_ff       <= '0;
         ready_ff      <= 1'b1;
         busy_ff       <= '0;
         run_dir_ff    <= '0;
         run_cnt_ff    <= '0;
      end else begin
         if (home_we) begin
            x_ff <= POSITION_BITS'(32'(signed'(csr_wdata[15:0])));
         end else if (accept) begin
            x_ff <= x_in;
         end
         if (accept) begin
            y_ff       <= y_in;
            pen_ff     <= pen_in;
            phase_ff   <= phase_in;
            mask_ff    <= mask_in;
            ready_ff   <= ready_in;
            busy_ff    <= busy_in;
            run_dir_ff <= run_dir_in;
            run_cnt_ff <= run_cnt_in;
         end
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_X_LIMIT:   x_limit_ff <= csr_wdata[14:0];
               CSR_HOME_X:    ;
               CSR_STEP_TICK: step_ticks_ff <= csr_wdata;
               CSR_PEN_TICK:  pen_ticks_ff <= csr_wdata;
               CSR_IRQ_BITS:  irq_bits_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
   end

endmodule

@@ rtl/pstep_queue.sv @@
// short queue of decoded results between front and back
module pstep_queue
   import pstep_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  rsp_entry_type push_entry,
   output logic          full,
   input  logic          pop,
   output rsp_entry_type head,
   output logic          empty
);

   rsp_entry_type             slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_BITS-1:0] count_ff;
   logic                      do_push;
   logic                      do_pop;

   assign full    = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_BITS'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_BITS'(1);
         if (do_push && !do_pop) begin
            count_ff <= count_ff + QUEUE_CNT_BITS'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - QUEUE_CNT_BITS'(1);
         end
      end
   end

endmodule

@@ rtl/pstep_back.sv @@
// back end: sends each queued result as one to four response beats
module pstep_back
   import pstep_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  rsp_entry_type head,
   input  logic          empty,
   output logic          pop,
   pstep_rsp_if.source   rsp_bus
);

   logic [1:0] beat_ff, beat_in;
   logic       has_bytes;
   logic       is_last;
   logic       fire;

   assign has_bytes = (head.n_bytes != 3'd0);
   assign is_last   = !has_bytes || ({1'b0, beat_ff} == head.n_bytes - 3'd1);
   assign fire      = rsp_bus.valid && rsp_bus.ready;
   assign pop       = fire && is_last;

   assign rsp_bus.valid             = !empty;
   assign rsp_bus.out_byte          = has_bytes ? head.bytes[beat_ff] : 8'd0;
   assign rsp_bus.byte_valid        = has_bytes;
   assign rsp_bus.last              = is_last;
   assign rsp_bus.skip              = head.skip;
   assign rsp_bus.interrupt_request = head.irq;
   assign rsp_bus.error             = head.error;
   assign rsp_bus.at_limit          = head.at_limit;
   assign rsp_bus.pen_down          = head.pen_down;
   assign rsp_bus.x_position        = $signed(head.x_pos);
   assign rsp_bus.y_position        = $signed(head.y_pos);

   always_comb begin
      beat_in = beat_ff;
      if (fire) begin
         beat_in = is_last ? 2'd0 : beat_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= '0;
      end else begin
         beat_ff <= beat_in;
      end
   end

endmodule
